// File: rtl/vertex_transform_cull_project_core_defines.svh
// Assertion macros shared by the checker of the vertex transform core.
// Needs nothing else; files that assert include it by name.
`ifndef VERTEX_TRANSFORM_CULL_PROJECT_CORE_DEFINES_SVH
`define VERTEX_TRANSFORM_CULL_PROJECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VTCP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtcp checker: property failed");

// Next-cycle implication, disabled while reset is high.
`define VTCP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtcp checker: property failed");

// Next-cycle implication that is also checked through reset.
`define VTCP_ASSERT_NXT_NORST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vtcp checker: property failed");

`endif

// File: rtl/vtcp_pkg.sv
// Types and constants of the vertex transform, cull and project core.
// Used by every module of the core but vtcp_ram; depends on nothing.
`default_nettype none
package vtcp_pkg;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned NCOEFF        = 41;
  localparam int unsigned COEFF_AW      = 6;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FACE = 2'd1;
  localparam logic [1:0] OP_VERT = 2'd2;

  localparam logic [COEFF_AW-1:0] MV_BASE   = 6'd0;
  localparam logic [COEFF_AW-1:0] PROJ_BASE = 6'd16;
  localparam logic [COEFF_AW-1:0] NRM_BASE  = 6'd32;

  typedef enum logic [1:0] {CLS_LOAD, CLS_FACE, CLS_VERT} item_cls_t;

  typedef struct packed {
    item_cls_t                  cls;
    logic [COEFF_AW-1:0]        idx;
    logic signed [DATA_W-1:0]   px;
    logic signed [DATA_W-1:0]   py;
    logic signed [DATA_W-1:0]   pz;
    logic signed [DATA_W-1:0]   nx;
    logic signed [DATA_W-1:0]   ny;
    logic signed [DATA_W-1:0]   nz;
    logic signed [DATA_W-1:0]   u;
    logic signed [DATA_W-1:0]   v;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FACE, ST_EYE, ST_DOT, ST_CULL, ST_CLIP, ST_DIV, ST_NRM, ST_OUT
  } seq_state_t;
endpackage
`default_nettype wire

// File: rtl/vertex_transform_cull_project_core.sv
// Vertex transform, back-face cull and perspective divide core, Q16.16 by default.
// Depends on vtcp_pkg, vtcp_front, vtcp_queue and vtcp_back.
//
// Usage: one input channel (in_valid/in_stall) carries loads of the 41 matrix
// coefficients, face headers and vertices; one output channel
// (out_valid/out_stall) carries one result per vertex of a visible face.
// Coefficients must be loaded before the faces that use them.
// Items pass through a two-entry queue to a sequencer built around one
// 32x32 multiply-accumulate unit and a serial divider that yields one quotient
// bit per cycle.
// Work per item: a load or a dropped vertex only leaves the queue, a face
// header transforms the face normal, a culled vertex gets its eye position
// (the first vertex of a face adds the cull dot product), and a vertex of a
// visible face adds the clip transform, the three divides and the normal
// transform; a zero w skips the serial division in each of the three divides.
// Reset: synchronous, active high; clears the queue, closes any open face and
// empties the output register. Coefficients hold no value until loaded.
// When the receiver stalls, the finished result waits in the output register
// while the next item is already worked on; the sequencer holds before
// writing a second result, and the queue then fills and raises in_stall.
`default_nettype none
module vertex_transform_cull_project_core #(
  parameter int unsigned FRAC_BITS   = vtcp_pkg::FRAC_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = vtcp_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         operation,
  input  logic [vtcp_pkg::COEFF_AW-1:0]      coeff_index,
  input  logic signed [vtcp_pkg::DATA_W-1:0] px,
  input  logic signed [vtcp_pkg::DATA_W-1:0] py,
  input  logic signed [vtcp_pkg::DATA_W-1:0] pz,
  input  logic signed [vtcp_pkg::DATA_W-1:0] nx,
  input  logic signed [vtcp_pkg::DATA_W-1:0] ny,
  input  logic signed [vtcp_pkg::DATA_W-1:0] nz,
  input  logic signed [vtcp_pkg::DATA_W-1:0] tex_u,
  input  logic signed [vtcp_pkg::DATA_W-1:0] tex_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_x,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_y,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_z,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_nx,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_ny,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_nz,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_u,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_v,
  output logic [1:0]                         vertex_slot,
  output logic                               saturated
);
  import vtcp_pkg::*;

  logic  push, full, q_valid, q_pop;
  item_t push_item, q_item;

  vtcp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .coeff_index(coeff_index),
    .px         (px),
    .py         (py),
    .pz         (pz),
    .nx         (nx),
    .ny         (ny),
    .nz         (nz),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .full       (full),
    .push       (push),
    .push_item  (push_item)
  );

  vtcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_item)
  );

  vtcp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ndc_x      (ndc_x),
    .ndc_y      (ndc_y),
    .ndc_z      (ndc_z),
    .out_nx     (out_nx),
    .out_ny     (out_ny),
    .out_nz     (out_nz),
    .out_u      (out_u),
    .out_v      (out_v),
    .vertex_slot(vertex_slot),
    .saturated  (saturated)
  );
endmodule
`default_nettype wire

// File: rtl/vtcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the coefficient store.
`default_nettype none
module vtcp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/vtcp_div.sv
// Radix-2 restoring divider for the perspective divide, one quotient bit a cycle.
// Depends on vtcp_pkg.
`default_nettype none
module vtcp_div #(
  parameter int unsigned FRAC_BITS = vtcp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [vtcp_pkg::DATA_W-1:0] num,
  input  logic signed [vtcp_pkg::DATA_W-1:0] den,
  output logic                              done,
  output logic signed [vtcp_pkg::DATA_W-1:0] quot,
  output logic                              sat
);
  import vtcp_pkg::*;
  localparam int unsigned NW = DATA_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [NW-1:0]     q, q_new;
  logic [DATA_W-1:0] rem, dmag, nmag, dabs;
  logic [DATA_W:0]   rem_sh, rem_new;
  logic              neg, ge, pos_ovf, neg_ovf;

  always_comb begin
    nmag    = num[DATA_W-1] ? (~num + 1'b1) : num;
    dabs    = den[DATA_W-1] ? (~den + 1'b1) : den;
    rem_sh  = {rem, q[NW-1]};
    ge      = rem_sh >= {1'b0, dmag};
    rem_new = ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
    q_new   = {q[NW-2:0], ge};
    pos_ovf = |q_new[NW-1:DATA_W-1];
    neg_ovf = (|q_new[NW-1:DATA_W]) || (q_new[DATA_W-1] && (|q_new[DATA_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        if (den == '0) begin
          // Division by zero goes to the limit that matches the sign of the numerator, or to zero for a zero numerator.
          done <= 1'b1;
          sat  <= 1'b1;
          if (num == '0) begin
            quot <= '0;
          end else if (num[DATA_W-1]) begin
            quot <= {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            quot <= {1'b0, {(DATA_W-1){1'b1}}};
          end
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(NW);
          q    <= {nmag, {FRAC_BITS{1'b0}}};
          rem  <= '0;
          dmag <= dabs;
          neg  <= num[DATA_W-1] ^ den[DATA_W-1];
        end
      end else if (busy) begin
        rem <= rem_new[DATA_W-1:0];
        q   <= q_new;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) begin
            sat  <= pos_ovf;
            quot <= pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : q_new[DATA_W-1:0];
          end else begin
            sat  <= neg_ovf;
            quot <= neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : (~q_new[DATA_W-1:0] + 1'b1);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/vtcp_front.sv
// Input side: takes items from the input channel, sorts out the ones that
// do nothing and hands the rest to the queue. Depends on vtcp_pkg.
`default_nettype none
module vtcp_front (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [vtcp_pkg::COEFF_AW-1:0]        coeff_index,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   px,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   py,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   pz,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   nx,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   ny,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   nz,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   tex_u,
  input  logic signed [vtcp_pkg::DATA_W-1:0]   tex_v,
  input  logic                                 full,
  output logic                                 push,
  output vtcp_pkg::item_t                      push_item
);
  import vtcp_pkg::*;
  logic keep;

  assign in_stall = full;

  always_comb begin
    push_item     = '0;
    push_item.idx = coeff_index;
    push_item.px  = px;
    push_item.py  = py;
    push_item.pz  = pz;
    push_item.nx  = nx;
    push_item.ny  = ny;
    push_item.nz  = nz;
    push_item.u   = tex_u;
    push_item.v   = tex_v;
    keep          = 1'b0;
    unique case (operation)
      OP_LOAD: begin
        push_item.cls = CLS_LOAD;
        keep          = coeff_index < COEFF_AW'(NCOEFF);
      end
      OP_FACE: begin
        push_item.cls = CLS_FACE;
        keep          = 1'b1;
      end
      OP_VERT: begin
        push_item.cls = CLS_VERT;
        keep          = 1'b1;
      end
      default: begin
        push_item.cls = CLS_LOAD;
        keep          = 1'b0;
      end
    endcase
  end

  // Dropped items still complete their transfer; they just never reach the queue.
  assign push = in_valid && !in_stall && keep;
endmodule
`default_nettype wire

// File: rtl/vtcp_queue.sv
// Short FIFO of classified items between the input side and the sequencer.
// Depends on vtcp_pkg.
`default_nettype none
module vtcp_queue #(
  parameter int unsigned DEPTH = vtcp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vtcp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output vtcp_pkg::item_t head
);
  import vtcp_pkg::*;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = count == CW'(DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/vtcp_back.sv
// Sequencer: one shared multiply-accumulate unit walks the matrix products,
// the cull dot product and the normal transform; a serial divider does the
// divide by w. Holds the coefficient RAM. Depends on vtcp_pkg, vtcp_ram, vtcp_div.
`default_nettype none
module vtcp_back #(
  parameter int unsigned FRAC_BITS = vtcp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  vtcp_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_x,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_y,
  output logic signed [vtcp_pkg::DATA_W-1:0] ndc_z,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_nx,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_ny,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_nz,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_u,
  output logic signed [vtcp_pkg::DATA_W-1:0] out_v,
  output logic [1:0]                         vertex_slot,
  output logic                               saturated
);
  import vtcp_pkg::*;
  localparam int unsigned ACC_W = 2 * DATA_W - FRAC_BITS + 2;
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  seq_state_t state, state_next;
  logic [1:0] r, c, ph;
  logic signed [DATA_W-1:0] opnd [4];
  logic signed [DATA_W-1:0] n_reg [3];
  logic signed [DATA_W-1:0] fn [3];
  logic signed [DATA_W-1:0] eye [4];
  logic signed [DATA_W-1:0] clip [4];
  logic signed [DATA_W-1:0] nd [3];
  logic signed [DATA_W-1:0] nrm [3];
  logic signed [DATA_W-1:0] u_reg, v_reg, a_op, b_op, row_val;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, acc_sum;
  logic row_hi, row_lo, dot_pos, last_c, last_r, four_wide;
  logic face_visible, flag;
  logic [1:0] slot_count, slot_reg;

  logic                ram_we;
  logic [COEFF_AW-1:0] raddr;
  logic [DATA_W-1:0]   rdata;
  logic                div_start, div_done, div_sat;
  logic signed [DATA_W-1:0] div_q;

  vtcp_ram #(.WIDTH(DATA_W), .DEPTH(NCOEFF)) u_coeff (
    .clk  (clk),
    .we   (ram_we),
    .waddr(q_item.idx),
    .wdata(q_item.px),
    .raddr(raddr),
    .rdata(rdata)
  );

  vtcp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (clip[r]),
    .den  (clip[3]),
    .done (div_done),
    .quot (div_q),
    .sat  (div_sat)
  );

  // Operand selection, coefficient address and row result of the MAC unit.
  always_comb begin
    a_op  = $signed(rdata);
    b_op  = opnd[c];
    raddr = MV_BASE + {2'd0, c, r};
    unique case (state)
      ST_CLIP: begin
        b_op  = eye[c];
        raddr = PROJ_BASE + {2'd0, c, r};
      end
      ST_NRM: begin
        b_op  = n_reg[c];
        raddr = NRM_BASE + ({3'd0, c, 1'b0} + {4'd0, c}) + {4'd0, r};
      end
      ST_FACE: begin
        raddr = NRM_BASE + ({3'd0, c, 1'b0} + {4'd0, c}) + {4'd0, r};
      end
      ST_DOT: begin
        a_op = eye[c];
        b_op = fn[c];
      end
      default: begin
      end
    endcase
    four_wide = (state == ST_EYE) || (state == ST_CLIP);
    last_c    = four_wide ? (c == 2'd3) : (c == 2'd2);
    last_r    = four_wide ? (r == 2'd3) : (r == 2'd2);
    acc_sum   = acc + ACC_W'(prod >>> FRAC_BITS);
    row_hi    = !acc_sum[ACC_W-1] && (|acc_sum[ACC_W-2:DATA_W-1]);
    row_lo    = acc_sum[ACC_W-1] && !(&acc_sum[ACC_W-2:DATA_W-1]);
    row_val   = row_hi ? SAT_MAX : (row_lo ? SAT_MIN : acc_sum[DATA_W-1:0]);
    dot_pos   = !acc_sum[ACC_W-1] && (|acc_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.cls)
            CLS_LOAD: ram_we = 1'b1;
            CLS_FACE: state_next = ST_FACE;
            CLS_VERT: begin
              // With no face open the vertex is simply dropped.
              if (slot_count != 2'd3) begin
                state_next = ST_EYE;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FACE, ST_EYE, ST_CLIP, ST_NRM: begin
        if (ph == 2'd2 && last_c && last_r) begin
          unique case (state)
            ST_FACE: state_next = ST_IDLE;
            ST_EYE:  state_next = (slot_count == 2'd0) ? ST_DOT : ST_CULL;
            ST_CLIP: state_next = ST_DIV;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_DOT: begin
        if (ph == 2'd2 && last_c) begin
          state_next = ST_CULL;
        end
      end
      ST_CULL: state_next = face_visible ? ST_CLIP : ST_IDLE;
      ST_DIV: begin
        div_start = ph == 2'd0;
        if (ph == 2'd1 && div_done && r == 2'd2) begin
          state_next = ST_NRM;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph           <= '0;
      r            <= '0;
      c            <= '0;
      face_visible <= 1'b0;
      slot_count   <= 2'd3;
      out_valid    <= 1'b0;
      fn[0]        <= '0;
      fn[1]        <= '0;
      fn[2]        <= '0;
    end else begin
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          ph  <= '0;
          r   <= '0;
          c   <= '0;
          acc <= '0;
          if (q_pop) begin
            opnd[0]  <= q_item.px;
            opnd[1]  <= q_item.py;
            opnd[2]  <= q_item.pz;
            opnd[3]  <= ONE;
            n_reg[0] <= q_item.nx;
            n_reg[1] <= q_item.ny;
            n_reg[2] <= q_item.nz;
            u_reg    <= q_item.u;
            v_reg    <= q_item.v;
            flag     <= 1'b0;
          end
        end
        ST_FACE, ST_EYE, ST_CLIP, ST_NRM, ST_DOT: begin
          unique case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              prod <= a_op * b_op;
              ph   <= 2'd2;
            end
            default: begin
              ph <= 2'd0;
              if (last_c) begin
                acc <= '0;
                c   <= '0;
                r   <= (last_r || state == ST_DOT) ? 2'd0 : r + 2'd1;
                unique case (state)
                  ST_FACE: begin
                    fn[r] <= row_val;
                    if (last_r) begin
                      slot_count   <= 2'd0;
                      face_visible <= 1'b0;
                    end
                  end
                  ST_EYE: begin
                    eye[r] <= row_val;
                    flag   <= flag | row_hi | row_lo;
                  end
                  ST_CLIP: begin
                    clip[r] <= row_val;
                    flag    <= flag | row_hi | row_lo;
                  end
                  ST_NRM: begin
                    nrm[r] <= row_val;
                    flag   <= flag | row_hi | row_lo;
                  end
                  default: begin
                    face_visible <= dot_pos;
                  end
                endcase
              end else begin
                acc <= acc_sum;
                c   <= c + 2'd1;
              end
            end
          endcase
        end
        ST_CULL: begin
          slot_reg   <= slot_count;
          slot_count <= slot_count + 2'd1;
        end
        ST_DIV: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (div_done) begin
            nd[r] <= div_q;
            flag  <= flag | div_sat;
            ph    <= 2'd0;
            r     <= (r == 2'd2) ? 2'd0 : r + 2'd1;
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            ndc_x       <= nd[0];
            ndc_y       <= nd[1];
            ndc_z       <= nd[2];
            out_nx      <= nrm[0];
            out_ny      <= nrm[1];
            out_nz      <= nrm[2];
            out_u       <= u_reg;
            out_v       <= v_reg;
            vertex_slot <= slot_reg;
            saturated   <= flag;
          end
        end
        default: begin
          ph <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/vtcp_checker.sv
// Port-level checker for the vertex transform core, bound to its top level.
// Depends on vtcp_pkg and the assertion macros header.
`include "vertex_transform_cull_project_core_defines.svh"
`default_nettype none
module vtcp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [vtcp_pkg::DATA_W-1:0] ndc_x,
  input logic [1:0]                         vertex_slot,
  input logic                               saturated
);
  // A stalled result must stay put until it is transferred.
  `VTCP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(ndc_x) && $stable(vertex_slot) && $stable(saturated))
  // Reset empties the output register and the queue.
  `VTCP_ASSERT_NXT_NORST(a_reset_idle, clk, rst, !out_valid && !in_stall)
  // A face has three vertex positions only.
  `VTCP_ASSERT_IMP(a_slot_range, clk, rst, out_valid, vertex_slot != 2'd3)
  // No result can appear right after reset.
  `VTCP_ASSERT_IMP(a_no_early_result, clk, rst, $rose(out_valid), !$past(rst) && !$past(rst, 2))
endmodule

bind vertex_transform_cull_project_core vtcp_checker u_vtcp_checker (.*);
`default_nettype wire
